/* design/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the CRC engine checker.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge while reset is released.
`define ASSERT_SYNC(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Property checked on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

/* design/mvcrc_pkg.sv */
// ---------------------------------------------------------------------------
// mvcrc_pkg
// Types, register indexes and helper functions of the multi-variant CRC engine.
// ---------------------------------------------------------------------------
package mvcrc_pkg;

    localparam int unsigned CfgWidth  = 16;
    localparam int unsigned IdxWidth  = 2;
    localparam int unsigned ByteWidth = 8;
    localparam int unsigned CrcWidth  = 16;

    typedef enum logic [2:0] {
        VAR_CRC4      = 3'd0,
        VAR_CRC7      = 3'd1,
        VAR_CRC8      = 3'd2,
        VAR_CRC8_LSB  = 3'd3,
        VAR_CRC16_LSB = 3'd4,
        VAR_CRC16     = 3'd5
    } variant_t;

    typedef enum logic [IdxWidth-1:0] {
        CFG_IDX_VARIANT   = 2'd0,
        CFG_IDX_GENERATOR = 2'd1,
        CFG_IDX_START     = 2'd2
    } cfg_idx_t;

    // Configuration seen by the datapath.
    typedef struct packed {
        variant_t              variant;
        logic [CfgWidth-1:0]   generator;
        logic [CfgWidth-1:0]   start_value;
    } cfg_t;

    function automatic logic [7:0] flip8(input logic [7:0] x);
        logic [7:0] y;
        for (int i = 0; i < 8; i++) begin
            y[i] = x[7-i];
        end
        return y;
    endfunction

    // Places a polynomial or start value where the selected variant keeps it.
    function automatic logic [15:0] shape_value(input logic [15:0] v, input variant_t var_sel);
        logic [15:0] s;
        unique case (var_sel)
            VAR_CRC4:     s = {8'h00, v[3:0], 4'h0};
            VAR_CRC7:     s = {8'h00, v[6:0], 1'b0};
            VAR_CRC8:     s = {8'h00, v[7:0]};
            VAR_CRC8_LSB: s = {8'h00, flip8(v[7:0])};
            default:      s = v;
        endcase
        return s;
    endfunction

endpackage

/* design/mvcrc_step.sv */
// ---------------------------------------------------------------------------
// mvcrc_step
// One byte of CRC update: start-value load, eight shift-xor steps, result.
// ---------------------------------------------------------------------------
module mvcrc_step (
    input  mvcrc_pkg::cfg_t  cfg,
    input  logic [15:0]      remainder,
    input  logic             at_start,
    input  logic [7:0]       data_byte,
    output logic [15:0]      remainder_next,
    output logic [15:0]      crc_value
);
    import mvcrc_pkg::*;

    variant_t    var_eff;
    logic [15:0] poly;
    logic [15:0] base;

    // Codes 6 and 7 run as plain crc8.
    always_comb begin
        unique case (cfg.variant)
            VAR_CRC4, VAR_CRC7, VAR_CRC8, VAR_CRC8_LSB, VAR_CRC16_LSB, VAR_CRC16:
                var_eff = cfg.variant;
            default:
                var_eff = VAR_CRC8;
        endcase
    end

    assign poly = shape_value(cfg.generator, var_eff);
    assign base = at_start ? shape_value(cfg.start_value, var_eff) : remainder;

    always_comb begin
        logic [7:0]  r8;
        logic [15:0] r16;
        r8  = base[7:0] ^ data_byte;
        r16 = base;
        unique case (var_eff)
            VAR_CRC8_LSB: begin
                for (int k = 0; k < 8; k++) begin
                    r8 = r8[0] ? ((r8 >> 1) ^ poly[7:0]) : (r8 >> 1);
                end
                remainder_next = {8'h00, r8};
            end
            VAR_CRC16_LSB: begin
                r16 = base ^ {8'h00, data_byte};
                for (int k = 0; k < 8; k++) begin
                    r16 = r16[0] ? ((r16 >> 1) ^ poly) : (r16 >> 1);
                end
                remainder_next = r16;
            end
            VAR_CRC16: begin
                r16 = base ^ {data_byte, 8'h00};
                for (int k = 0; k < 8; k++) begin
                    r16 = r16[15] ? ((r16 << 1) ^ poly) : (r16 << 1);
                end
                remainder_next = r16;
            end
            default: begin
                for (int k = 0; k < 8; k++) begin
                    r8 = r8[7] ? ((r8 << 1) ^ poly[7:0]) : (r8 << 1);
                end
                remainder_next = {8'h00, r8};
            end
        endcase
    end

    always_comb begin
        unique case (var_eff)
            VAR_CRC4:                crc_value = {12'h000, remainder_next[7:4]};
            VAR_CRC7:                crc_value = {9'h000, remainder_next[7:1]};
            VAR_CRC8, VAR_CRC8_LSB:  crc_value = {8'h00, remainder_next[7:0]};
            default:                 crc_value = remainder_next;
        endcase
    end

endmodule

/* design/multi_variant_crc_engine.sv */
// ---------------------------------------------------------------------------
// multi_variant_crc_engine
// Byte-stream CRC engine with six selectable 4, 7, 8 and 16 bit variants.
// ---------------------------------------------------------------------------
//
//  Channel   Direction  Payload                      Marker
//  s_        in         tdata[7:0] = data_byte       tlast = final_byte
//  m_        out        tdata[15:0] = crc_value      none
//  cfg_      in         wdata = register value       addr = register index
//
// One word is taken every cycle unless a last byte waits in the input register
// facing a full result register. A byte's eight shift-xor steps run from the
// input register into the remainder and, on the last byte, into the result
// register, which drives m_. The remainder feedback through the eight-step
// update sets the one-word-per-cycle rate.
// Reset (aresetn low, synchronous) empties both registers, restores the
// register defaults and arms the block for the start of a message.
// A stalled result blocks only a last byte, and the bytes behind it wait.
//
module multi_variant_crc_engine (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Input stream.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [mvcrc_pkg::ByteWidth-1:0]   s_tdata,   // [7:0] data_byte
    input  logic                              s_tlast,   // final_byte
    // Result stream.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [mvcrc_pkg::CrcWidth-1:0]    m_tdata,   // [15:0] crc_value
    // Configuration write port.
    input  logic                              cfg_wr_en,
    input  logic [mvcrc_pkg::IdxWidth-1:0]    cfg_addr,
    input  logic [mvcrc_pkg::CfgWidth-1:0]    cfg_wdata
);
    import mvcrc_pkg::*;

    cfg_t                 cfg_reg;
    logic [15:0]          rem_reg;
    logic                 at_start_reg;
    logic                 in_valid_reg;
    logic [7:0]           in_byte_reg;
    logic                 in_last_reg;
    logic                 out_valid_reg;
    logic [CrcWidth-1:0]  out_crc_reg;

    logic [15:0]          rem_next;
    logic [15:0]          crc_next;
    logic                 out_free;
    logic                 advance;
    logic                 s_accept;

    // The result register is free when empty or being drained this cycle.
    assign out_free = !out_valid_reg || m_tready;
    // A byte leaves the input register unless it is a last byte facing a
    // full result register.
    assign advance  = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    mvcrc_step u_step (
        .cfg            (cfg_reg),
        .remainder      (rem_reg),
        .at_start       (at_start_reg),
        .data_byte      (in_byte_reg),
        .remainder_next (rem_next),
        .crc_value      (crc_next)
    );

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.variant     <= VAR_CRC8;
            cfg_reg.generator   <= 16'h0007;
            cfg_reg.start_value <= 16'h0000;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_IDX_VARIANT:   cfg_reg.variant     <= variant_t'(cfg_wdata[2:0]);
                CFG_IDX_GENERATOR: cfg_reg.generator   <= cfg_wdata;
                CFG_IDX_START:     cfg_reg.start_value <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // Running remainder; a last byte re-arms the start-value load.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg      <= 16'h0000;
            at_start_reg <= 1'b1;
        end else if (advance) begin
            rem_reg      <= rem_next;
            at_start_reg <= in_last_reg;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && in_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_last_reg) begin
            out_crc_reg <= crc_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_crc_reg;

endmodule

/* design/mvcrc_checker.sv */
// ---------------------------------------------------------------------------
// mvcrc_checker
// Port-level assertions for the multi-variant CRC engine, bound to the top.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mvcrc_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [mvcrc_pkg::CrcWidth-1:0]    m_tdata
);

    // A stalled result holds its value.
    `ASSERT_SYNC(a_result_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))

    // Reset leaves no result pending and the input open.
    `ASSERT_ALWAYS(a_reset_clears, aclk, !aresetn |=> (!m_tvalid && s_tready))

    // With the result register empty nothing can hold back the input.
    `ASSERT_SYNC(a_ready_when_empty, aclk, aresetn, !m_tvalid |-> s_tready)

endmodule

bind multi_variant_crc_engine mvcrc_checker u_mvcrc_checker (.*);
